@@ hdl/svpg_pkg.sv @@
package svpg_pkg;

    // field and register widths
    localparam int KIND_W   = 2;
    localparam int STEPS_W  = 21;
    localparam int VEL_W    = 24;
    localparam int PERIOD_W = 20;
    localparam int SPR_W    = 16;
    localparam int PW_W     = 10;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // velocity conversion: |v| * steps_per_rev / 5760, rounded half up
    localparam int PROD_W = VEL_W + SPR_W;
    localparam int DEG_W  = 13;
    localparam logic [DEG_W-1:0]  Q4_DEG_PER_REV = 13'd5760;
    localparam logic [PROD_W-1:0] Q4_HALF_REV    = 40'd2880;

    // rate limit in steps per second
    localparam logic [PERIOD_W-1:0] MAX_RATE = 20'd1000000;

    // reset values
    localparam logic [SPR_W-1:0] SPR_RESET = 16'd200;
    localparam logic [PW_W-1:0]  PW_RESET  = 10'd5;

    localparam int TICKS_PER_SECOND_DEF = 1000000;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_RATE = 2'd1,
        KIND_VEL  = 2'd2,
        KIND_STOP = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPR = 1'b0,
        CFG_PW  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VEL,
        S_MUL,
        S_QDIV,
        S_RATE,
        S_PDIV,
        S_DONE
    } t_state;

    // handshake between the sequencer and a serial unit
    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_rsp;

endpackage

@@ hdl/svpg_mul.sv @@
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
module svpg_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  svpg_pkg::t_unit_req              i_req,
    input  logic [svpg_pkg::VEL_W-1:0]       i_a,
    input  logic [svpg_pkg::SPR_W-1:0]       i_b,
    output svpg_pkg::t_unit_rsp              o_rsp,
    output logic [svpg_pkg::PROD_W-1:0]      o_product
);

    localparam int A_W   = svpg_pkg::VEL_W;
    localparam int B_W   = svpg_pkg::SPR_W;
    localparam int CNT_W = $clog2(B_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_a;
    logic [A_W-1:0]   r_hi;
    logic [B_W-1:0]   r_lo;
    logic [A_W:0]     n_sum;

    // partial sum of the upper half for the current multiplier bit
    assign n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(A_W+1){1'b0}});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath: add, then shift the {hi, lo} pair right by one
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= n_sum[A_W:1];
            r_lo <= {n_sum[0], r_lo[B_W-1:1]};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_product  = {r_hi, r_lo};

endmodule

@@ hdl/svpg_div.sv @@
// Restoring divider: one quotient bit per cycle, MSB first.
module svpg_div #(
    parameter int N_W = svpg_pkg::PROD_W,
    parameter int D_W = svpg_pkg::DEG_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  svpg_pkg::t_unit_req i_req,
    input  logic [N_W-1:0]      i_dividend,
    input  logic [D_W-1:0]      i_divisor,
    output svpg_pkg::t_unit_rsp o_rsp,
    output logic [N_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(N_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_d;
    logic [N_W-1:0]   r_q;
    logic [D_W:0]     n_shift;
    logic [D_W:0]     n_diff;
    logic             n_ge;

    // trial subtract of the divisor from the shifted remainder
    assign n_shift = {r_rem, r_q[N_W-1]};
    assign n_ge    = (n_shift >= {1'b0, r_d});
    assign n_diff  = n_shift - {1'b0, r_d};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out the top while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_d   <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[D_W-1:0] : n_shift[D_W-1:0];
            r_q   <= {r_q[N_W-2:0], n_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quotient = r_q;

endmodule

@@ hdl/stepper_velocity_pulse_generator.sv @@
// Step/direction pulse generator. Each input word is a microsecond tick, a rate in
// steps/s, a velocity in 1/16 deg/s, or a stop; each gives one output word with the
// direction, step pin level, running flag and current period. A steps/s command
// uses the 20-step restoring divider to form TICKS_PER_SECOND/|rate|. A velocity
// command runs the bit-serial multiply by steps_per_rev, then the restoring
// division by 5760, then the period division. One word is in work at a time;
// the next word is taken while a finished one still waits at the output.
module stepper_velocity_pulse_generator #(
    parameter int TICKS_PER_SECOND = svpg_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [svpg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [svpg_pkg::CFG_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [svpg_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [svpg_pkg::STEPS_W-1:0]  i_steps_rate,
    input  logic signed [svpg_pkg::VEL_W-1:0]    i_velocity_q4,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_dir_level,
    output logic                                 o_pulse_level,
    output logic                                 o_running,
    output logic [svpg_pkg::PERIOD_W-1:0]        o_period_ticks
);

    localparam int P_W = svpg_pkg::PERIOD_W;
    localparam logic [P_W-1:0] TPS = P_W'(TICKS_PER_SECOND);

    // configuration registers
    logic [svpg_pkg::SPR_W-1:0] r_spr;
    logic [svpg_pkg::PW_W-1:0]  r_pw;

    // generator state
    logic           r_dir;
    logic           r_pulse;
    logic           r_active;
    logic [P_W-1:0] r_period;
    logic [P_W-1:0] r_alarm;

    // per-word work registers
    svpg_pkg::t_state            r_state;
    svpg_pkg::t_state            n_state;
    svpg_pkg::t_kind             r_kind;
    logic [svpg_pkg::VEL_W-1:0]  r_vabs;
    logic                        r_vneg;
    logic [P_W-1:0]              r_mag;
    logic                        r_dir_new;
    logic [P_W-1:0]              r_p;
    logic                        r_out_valid;

    // accept and commit strobes
    logic in_accept;
    logic out_free;
    logic commit;

    // serial units
    svpg_pkg::t_unit_req          mul_req;
    svpg_pkg::t_unit_rsp          mul_rsp;
    logic [svpg_pkg::PROD_W-1:0]  mul_prod;
    svpg_pkg::t_unit_req          qdiv_req;
    svpg_pkg::t_unit_rsp          qdiv_rsp;
    logic [svpg_pkg::PROD_W-1:0]  qdiv_q;
    svpg_pkg::t_unit_req          pdiv_req;
    svpg_pkg::t_unit_rsp          pdiv_rsp;
    logic [P_W-1:0]               pdiv_q;

    // input decode
    logic [svpg_pkg::STEPS_W-1:0] n_rabs;
    logic [P_W-1:0]               n_rsat;
    logic [svpg_pkg::VEL_W-1:0]   n_vabs;
    logic [svpg_pkg::PROD_W-1:0]  n_dividend;
    logic [P_W-1:0]               n_qsat;

    // effective width and clamp
    logic [svpg_pkg::PW_W-1:0] n_w;
    logic [P_W-1:0]            n_wp1;
    logic [P_W-1:0]            n_wext;
    logic [P_W-1:0]            n_pclamp;

    // next generator state
    logic           n_dir;
    logic           n_pulse;
    logic           n_active;
    logic [P_W-1:0] n_period;
    logic [P_W-1:0] n_alarm;
    logic [P_W-1:0] n_adec;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign commit    = (r_state == svpg_pkg::S_DONE) && out_free;

    // magnitudes of the signed inputs
    assign n_rabs = i_steps_rate[svpg_pkg::STEPS_W-1] ? (~i_steps_rate + 1'b1) : i_steps_rate;
    assign n_rsat = (n_rabs > svpg_pkg::STEPS_W'(svpg_pkg::MAX_RATE)) ?
                    svpg_pkg::MAX_RATE : n_rabs[P_W-1:0];
    assign n_vabs = i_velocity_q4[svpg_pkg::VEL_W-1] ? (~i_velocity_q4 + 1'b1) : i_velocity_q4;

    // round half up before the division by 5760
    assign n_dividend = mul_prod + svpg_pkg::Q4_HALF_REV;
    assign n_qsat = (qdiv_q > svpg_pkg::PROD_W'(svpg_pkg::MAX_RATE)) ?
                    svpg_pkg::MAX_RATE : qdiv_q[P_W-1:0];

    // a zero width acts as one
    assign n_w      = (r_pw == '0) ? svpg_pkg::PW_W'(1) : r_pw;
    assign n_wext   = P_W'(n_w);
    assign n_wp1    = n_wext + 1'b1;
    assign n_pclamp = (pdiv_q < n_wp1) ? n_wp1 : pdiv_q;

    // serial units
    svpg_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mul_req),
        .i_a       (r_vabs),
        .i_b       (r_spr),
        .o_rsp     (mul_rsp),
        .o_product (mul_prod)
    );

    svpg_div #(
        .N_W (svpg_pkg::PROD_W),
        .D_W (svpg_pkg::DEG_W)
    ) u_qdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (qdiv_req),
        .i_dividend (n_dividend),
        .i_divisor  (svpg_pkg::Q4_DEG_PER_REV),
        .o_rsp      (qdiv_rsp),
        .o_quotient (qdiv_q)
    );

    svpg_div #(
        .N_W (P_W),
        .D_W (P_W)
    ) u_pdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (pdiv_req),
        .i_dividend (TPS),
        .i_divisor  (r_mag),
        .o_rsp      (pdiv_rsp),
        .o_quotient (pdiv_q)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            svpg_pkg::S_IDLE: begin
                if (in_accept) begin
                    unique case (svpg_pkg::t_kind'(i_kind))
                        svpg_pkg::KIND_TICK: n_state = svpg_pkg::S_DONE;
                        svpg_pkg::KIND_RATE: n_state = svpg_pkg::S_RATE;
                        svpg_pkg::KIND_VEL:  n_state = svpg_pkg::S_VEL;
                        svpg_pkg::KIND_STOP: n_state = svpg_pkg::S_DONE;
                        default:             n_state = svpg_pkg::S_DONE;
                    endcase
                end
            end
            svpg_pkg::S_VEL: n_state = svpg_pkg::S_MUL;
            svpg_pkg::S_MUL: begin
                if (mul_rsp.done) begin
                    n_state = svpg_pkg::S_QDIV;
                end
            end
            svpg_pkg::S_QDIV: begin
                if (qdiv_rsp.done) begin
                    n_state = svpg_pkg::S_RATE;
                end
            end
            svpg_pkg::S_RATE: begin
                n_state = (r_mag == '0) ? svpg_pkg::S_DONE : svpg_pkg::S_PDIV;
            end
            svpg_pkg::S_PDIV: begin
                if (pdiv_rsp.done) begin
                    n_state = svpg_pkg::S_DONE;
                end
            end
            svpg_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = svpg_pkg::S_IDLE;
                end
            end
            default: n_state = svpg_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall     = (r_state != svpg_pkg::S_IDLE);
        mul_req.start  = (r_state == svpg_pkg::S_VEL);
        qdiv_req.start = (r_state == svpg_pkg::S_MUL) && mul_rsp.done;
        pdiv_req.start = (r_state == svpg_pkg::S_RATE) && (r_mag != '0);
    end

    // next generator state for the word being committed
    always_comb begin
        n_dir    = r_dir;
        n_pulse  = r_pulse;
        n_active = r_active;
        n_period = r_period;
        n_alarm  = r_alarm;
        n_adec   = (r_alarm != '0) ? (r_alarm - 1'b1) : r_alarm;
        unique case (r_kind)
            svpg_pkg::KIND_TICK: begin
                if (r_active) begin
                    n_alarm = n_adec;
                    if (n_adec == '0) begin
                        if (r_period == '0) begin
                            n_pulse  = 1'b0;
                            n_active = 1'b0;
                        end else if (!r_pulse) begin
                            n_pulse = 1'b1;
                            n_alarm = n_wext;
                        end else begin
                            n_pulse = 1'b0;
                            n_alarm = (r_period > n_wext) ? (r_period - n_wext) : P_W'(1);
                        end
                    end
                end
            end
            svpg_pkg::KIND_RATE, svpg_pkg::KIND_VEL: begin
                n_dir = r_dir_new;
                if (r_mag == '0) begin
                    n_period = '0;
                    n_pulse  = 1'b0;
                    n_active = 1'b0;
                end else begin
                    n_period = r_p;
                    n_alarm  = P_W'(1);
                    n_active = 1'b1;
                end
            end
            svpg_pkg::KIND_STOP: begin
                n_period = '0;
                n_pulse  = 1'b0;
                n_active = 1'b0;
            end
            default: begin
                n_dir = r_dir;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr <= svpg_pkg::SPR_RESET;
            r_pw  <= svpg_pkg::PW_RESET;
        end else if (i_cfg_we) begin
            unique case (svpg_pkg::t_cfg_idx'(i_cfg_index))
                svpg_pkg::CFG_SPR: r_spr <= i_cfg_data[svpg_pkg::SPR_W-1:0];
                svpg_pkg::CFG_PW:  r_pw  <= i_cfg_data[svpg_pkg::PW_W-1:0];
                default:           r_spr <= r_spr;
            endcase
        end
    end

    // sequencer, generator state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svpg_pkg::S_IDLE;
            r_dir       <= 1'b0;
            r_pulse     <= 1'b0;
            r_active    <= 1'b0;
            r_period    <= '0;
            r_alarm     <= P_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_dir    <= n_dir;
                r_pulse  <= n_pulse;
                r_active <= n_active;
                r_period <= n_period;
                r_alarm  <= n_alarm;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // word capture and intermediate results
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind    <= svpg_pkg::t_kind'(i_kind);
            r_vabs    <= n_vabs;
            r_vneg    <= i_velocity_q4[svpg_pkg::VEL_W-1];
            r_mag     <= n_rsat;
            r_dir_new <= !i_steps_rate[svpg_pkg::STEPS_W-1];
        end else if ((r_state == svpg_pkg::S_QDIV) && qdiv_rsp.done) begin
            // a negative velocity that rounds to zero counts as forward
            r_mag     <= n_qsat;
            r_dir_new <= !r_vneg || (qdiv_q == '0);
        end
        if ((r_state == svpg_pkg::S_PDIV) && pdiv_rsp.done) begin
            r_p <= n_pclamp;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (commit) begin
            o_dir_level    <= n_dir;
            o_pulse_level  <= n_pulse;
            o_running      <= n_active;
            o_period_ticks <= n_period;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
